// File: hw/rtl/ldcs_pkg.sv
// Shared types and constants for the layered draw command sorter.
// No dependencies; used by all ldcs modules and the top level.
package ldcs_pkg;

   localparam int LAYER_W = 16;
   localparam int KIND_W  = 4;
   localparam int POS_W   = 32;
   localparam int SEQ_W   = 6;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_LOAD,
      ST_SHOW
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic push;       // accepted command, store it if there is room
      logic frame_end;  // close the frame: latch overflow, clear count
      logic load;       // pop head of chain, read its payload
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;       // presented result is the final one of the frame
   } dp_status_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
   } entry_type;

endpackage

// File: hw/rtl/ldcs_ctrl.sv
// Frame controller for the layered draw command sorter.
// Depends on ldcs_pkg (state, command and status types).
module ldcs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_end_of_frame,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ldcs_pkg::ctrl_cmd_type cmd,
   input  ldcs_pkg::dp_status_type status
);

   ldcs_pkg::state_type state_ff, state_in;
   logic                req_xfer;

   assign req_xfer = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ldcs_pkg::ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ldcs_pkg::ST_COLLECT: begin
            if (req_xfer && req_end_of_frame) begin
               state_in = ldcs_pkg::ST_LOAD;
            end
         end
         ldcs_pkg::ST_LOAD: begin
            state_in = ldcs_pkg::ST_SHOW;
         end
         ldcs_pkg::ST_SHOW: begin
            if (!rsp_stall) begin
               state_in = status.last ? ldcs_pkg::ST_COLLECT : ldcs_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = ldcs_pkg::ST_COLLECT;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      cmd.push      = 1'b0;
      cmd.frame_end = 1'b0;
      cmd.load      = 1'b0;
      case (state_ff)
         ldcs_pkg::ST_COLLECT: begin
            req_stall     = 1'b0;
            cmd.push      = req_valid;
            cmd.frame_end = req_valid && req_end_of_frame;
         end
         ldcs_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ldcs_pkg::ST_SHOW: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// File: hw/rtl/ldcs_datapath.sv
// Datapath: sorted key chain, payload store and result registers.
// Depends on ldcs_pkg (command, status and entry types, field widths).
module ldcs_datapath #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ldcs_pkg::ctrl_cmd_type              cmd,
   output ldcs_pkg::dp_status_type             status,
   input  logic signed [ldcs_pkg::LAYER_W-1:0] req_layer,
   input  logic [ldcs_pkg::KIND_W-1:0]         req_draw_kind,
   input  logic [ldcs_pkg::POS_W-1:0]          req_pos_x,
   input  logic [ldcs_pkg::POS_W-1:0]          req_pos_y,
   output logic signed [ldcs_pkg::LAYER_W-1:0] rsp_out_layer,
   output logic [ldcs_pkg::SEQ_W-1:0]          rsp_out_sequence,
   output logic [ldcs_pkg::KIND_W-1:0]         rsp_out_kind,
   output logic [ldcs_pkg::POS_W-1:0]          rsp_out_x,
   output logic [ldcs_pkg::POS_W-1:0]          rsp_out_y,
   output logic                                rsp_frame_overflowed,
   output logic                                rsp_last_out
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // key chain: kept sorted by layer, ties in arrival order
   logic signed [ldcs_pkg::LAYER_W-1:0] key_layer_ff [QUEUE_DEPTH];
   logic signed [ldcs_pkg::LAYER_W-1:0] key_layer_in [QUEUE_DEPTH];
   logic [AW-1:0]                       key_seq_ff   [QUEUE_DEPTH];
   logic [AW-1:0]                       key_seq_in   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]              key_valid_ff, key_valid_in;
   logic [QUEUE_DEPTH-1:0]              behind;  // cell goes after new key

   ldcs_pkg::entry_type                 store [QUEUE_DEPTH];
   ldcs_pkg::entry_type                 rd_ff;

   logic [CW-1:0]                       count_ff, count_in;
   logic                                ovf_ff, ovf_in;
   logic                                full;
   logic                                insert;

   logic signed [ldcs_pkg::LAYER_W-1:0] head_layer_ff;
   logic [AW-1:0]                       head_seq_ff;
   logic                                frame_ovf_ff, frame_ovf_in;
   logic                                last_ff;

   assign full   = (count_ff == CW'(QUEUE_DEPTH));
   assign insert = cmd.push && !full;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign behind[i] = !key_valid_ff[i] || (key_layer_ff[i] > req_layer);

      always_comb begin
         key_layer_in[i] = key_layer_ff[i];
         key_seq_in[i]   = key_seq_ff[i];
         key_valid_in[i] = key_valid_ff[i];
         if (insert && behind[i]) begin
            if (i == 0) begin
               key_layer_in[i] = req_layer;
               key_seq_in[i]   = count_ff[AW-1:0];
               key_valid_in[i] = 1'b1;
            end else if (!behind[(i > 0) ? i - 1 : 0]) begin
               key_layer_in[i] = req_layer;
               key_seq_in[i]   = count_ff[AW-1:0];
               key_valid_in[i] = 1'b1;
            end else begin
               key_layer_in[i] = key_layer_ff[(i > 0) ? i - 1 : 0];
               key_seq_in[i]   = key_seq_ff[(i > 0) ? i - 1 : 0];
               key_valid_in[i] = key_valid_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.load) begin
            if (i == QUEUE_DEPTH - 1) begin
               key_valid_in[i] = 1'b0;
            end else begin
               key_layer_in[i] = key_layer_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
               key_seq_in[i]   = key_seq_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
               key_valid_in[i] = key_valid_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
         end
      end

      always_ff @(posedge clock) begin
         key_layer_ff[i] <= key_layer_in[i];
         key_seq_ff[i]   <= key_seq_in[i];
      end
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      frame_ovf_in = frame_ovf_ff;
      if (cmd.push) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.frame_end) begin
         frame_ovf_in = ovf_ff || full;
         ovf_in       = 1'b0;
         count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         key_valid_ff <= key_valid_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
      end
   end

   // payload store, addressed by arrival index
   always_ff @(posedge clock) begin
      if (insert) begin
         store[count_ff[AW-1:0]] <= '{kind: req_draw_kind, x: req_pos_x, y: req_pos_y};
      end
      if (cmd.load) begin
         rd_ff <= store[key_seq_ff[0]];
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      frame_ovf_ff <= frame_ovf_in;
      if (cmd.load) begin
         head_layer_ff <= key_layer_ff[0];
         head_seq_ff   <= key_seq_ff[0];
         last_ff       <= (QUEUE_DEPTH > 1) ? !key_valid_ff[(QUEUE_DEPTH > 1) ? 1 : 0] : 1'b1;
      end
   end

   assign status.last          = last_ff;
   assign rsp_out_layer        = head_layer_ff;
   assign rsp_out_sequence     = ldcs_pkg::SEQ_W'(head_seq_ff);
   assign rsp_out_kind         = rd_ff.kind;
   assign rsp_out_x            = rd_ff.x;
   assign rsp_out_y            = rd_ff.y;
   assign rsp_frame_overflowed = frame_ovf_ff;
   assign rsp_last_out         = last_ff;

endmodule

// File: hw/rtl/layered_draw_command_sorter.sv
// Top level of the layered draw command sorter.
// Depends on ldcs_pkg, ldcs_ctrl and ldcs_datapath.
//
// Usage:
//   req_* carries draw commands, one transfer per cycle while req_stall is
//   low. Each command is placed in a key chain that stays sorted by signed
//   layer (ties keep arrival order) and its payload is written to the store
//   at its arrival index. Once QUEUE_DEPTH commands are held, further
//   commands are dropped and the frame is flagged as overflowed.
//   A command with end_of_frame set closes the frame (stored first if there
//   is room). req_stall then stays high while the frame drains on rsp_*.
//   Results leave in ascending layer order; rsp_last_out marks the last one
//   and rsp_frame_overflowed is constant over the frame.
// Drain:
//   After the end-of-frame transfer each result takes a load step (pop the
//   chain head and read the store) and then a show step that presents it;
//   the show step is held for as long as rsp_stall is high. Input reopens
//   the cycle after the last result transfer.
// Reset: synchronous, clears the controller, chain valid bits, entry count
//   and overflow flag. Store contents are left as they are.
// Stall: while rsp_stall is high the presented result and all state hold.
module layered_draw_command_sorter #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ldcs_pkg::LAYER_W-1:0] req_layer,
   input  logic [ldcs_pkg::KIND_W-1:0]         req_draw_kind,
   input  logic [ldcs_pkg::POS_W-1:0]          req_pos_x,
   input  logic [ldcs_pkg::POS_W-1:0]          req_pos_y,
   input  logic                                req_end_of_frame,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ldcs_pkg::LAYER_W-1:0] rsp_out_layer,
   output logic [ldcs_pkg::SEQ_W-1:0]          rsp_out_sequence,
   output logic [ldcs_pkg::KIND_W-1:0]         rsp_out_kind,
   output logic [ldcs_pkg::POS_W-1:0]          rsp_out_x,
   output logic [ldcs_pkg::POS_W-1:0]          rsp_out_y,
   output logic                                rsp_frame_overflowed,
   output logic                                rsp_last_out
);

   ldcs_pkg::ctrl_cmd_type  cmd;
   ldcs_pkg::dp_status_type status;

   ldcs_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_frame (req_end_of_frame),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .status           (status)
   );

   ldcs_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_layer            (req_layer),
      .req_draw_kind        (req_draw_kind),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .rsp_out_layer        (rsp_out_layer),
      .rsp_out_sequence     (rsp_out_sequence),
      .rsp_out_kind         (rsp_out_kind),
      .rsp_out_x            (rsp_out_x),
      .rsp_out_y            (rsp_out_y),
      .rsp_frame_overflowed (rsp_frame_overflowed),
      .rsp_last_out         (rsp_last_out)
   );

endmodule

// File: hw/rtl/ldcs_checker.sv
// Port-level checks for the layered draw command sorter.
// Depends on layered_draw_command_sorter; bound to it at the end of this file.
module ldcs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_end_of_frame,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [ldcs_pkg::LAYER_W-1:0] rsp_out_layer,
   input logic [ldcs_pkg::SEQ_W-1:0]          rsp_out_sequence,
   input logic                                rsp_last_out
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_layer)
         && $stable(rsp_out_sequence) && $stable(rsp_last_out))
      else $error("stalled result changed");

   // no input transfer while a frame drains
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during drain");

   // closing a frame shuts the input
   a_eof_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_frame |=> req_stall)
      else $error("input open after end of frame");

   // the last result ends the drain
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_out |=> !rsp_valid && !req_stall)
      else $error("drain did not end after last result");

   // nothing shows right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind layered_draw_command_sorter ldcs_checker u_ldcs_checker (.*);
